// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// assertion held off while reset is high
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// assertion checked at every edge, reset included
`define ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(label, clk, rst, prop, msg)

`define ASSERT_ALL(label, clk, prop, msg)

`endif

`endif

// File: sv/clws_pkg.sv
// ----------------------------------------------------------------------------
// clws_pkg
// Types, codes and constants of the character LCD write sequencer.
// ----------------------------------------------------------------------------
package clws_pkg;

   localparam int LINE_CHARS_DEFAULT = 16;

   // request codes
   localparam logic [2:0] CMD_INIT   = 3'd0;
   localparam logic [2:0] CMD_RAW    = 3'd1;
   localparam logic [2:0] CMD_CHAR   = 3'd2;
   localparam logic [2:0] CMD_CURSOR = 3'd3;
   localparam logic [2:0] CMD_NUMBER = 3'd4;

   // configuration register indexes
   localparam int         CSR_INDEX_W         = 1;
   localparam logic [0:0] CSR_FUNCTION_SET    = 1'd0;
   localparam logic [0:0] CSR_DISPLAY_CONTROL = 1'd1;

   localparam logic [7:0] FUNCTION_SET_RESET    = 8'h3C;
   localparam logic [7:0] DISPLAY_CONTROL_RESET = 8'h0F;

   localparam logic [7:0] CLEAR_DISPLAY = 8'h01;
   localparam logic [7:0] DDRAM_SET     = 8'h80;
   localparam logic [7:0] LINE2_BASE    = 8'h40;
   localparam logic [7:0] ASCII_ZERO    = 8'd48;

   localparam int         DIG_W     = 3;
   localparam logic [2:0] DIG_LAST  = 3'd4;
   localparam int         WEIGHT_W  = 17;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT0,
      S_INIT1,
      S_INIT2,
      S_SINGLE,
      S_DATA,
      S_WRAP,
      S_CALC
   } state_type;

   // weight tried at one restoring step: 10^(4-dig) * 2^(3-step)
   function automatic logic [WEIGHT_W-1:0] digit_weight(input logic [DIG_W-1:0] dig,
                                                         input logic [1:0] step);
      logic [WEIGHT_W-1:0] base;
      case (dig)
         3'd0:    base = 17'd10000;
         3'd1:    base = 17'd1000;
         3'd2:    base = 17'd100;
         3'd3:    base = 17'd10;
         default: base = 17'd1;
      endcase
      return base << (2'd3 - step);
   endfunction

endpackage

// File: sv/clws_if.sv
// ----------------------------------------------------------------------------
// clws channel interfaces
// Valid/ready channels for display requests and LCD bus writes.
// ----------------------------------------------------------------------------
interface clws_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [7:0]  byte_value;
   logic        row;
   logic [5:0]  column;
   logic [15:0] number;

   modport source (output valid, command, byte_value, row, column, number,
                   input ready);
   modport sink   (input valid, command, byte_value, row, column, number,
                   output ready);
endinterface

interface clws_rsp_if;
   logic       valid;
   logic       ready;
   logic       reg_select;
   logic [7:0] bus_byte;
   logic       last;

   modport source (output valid, reg_select, bus_byte, last, input ready);
   modport sink   (input valid, reg_select, bus_byte, last, output ready);
endinterface

// File: sv/char_lcd_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Turns display requests into runs of LCD bus writes (instruction or data),
// with decimal printing and automatic line wrap.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  req_ch    in   valid/ready   command, byte_value, row, column, number
//  rsp_ch    out  valid/ready   reg_select, bus_byte, last
//  csr_*     in   write enable  csr_index, csr_wdata
//
//  One item at a time: accepted while idle, then one write per cycle in the
//  write states while the output register is free. Writes: init 3, raw/cursor
//  1, char 1 or 2 (line wrap), number up to 6, each digit found by restoring
//  steps on the shared compare/subtract unit over 5 decimal places.
//  Synchronous reset clears control state and the character count.
//  A stalled rsp_ch holds the sequencer in its write states; req_ch is ready whenever idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module char_lcd_write_sequencer #(
   parameter int LINE_CHARS = clws_pkg::LINE_CHARS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   clws_req_if.sink                        req_ch,
   clws_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [clws_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_wdata
);
   import clws_pkg::*;

   localparam int CNT_W = $clog2(2 * LINE_CHARS);

   state_type            state_ff, state_in;
   logic [7:0]           fset_ff, dctl_ff;
   logic [7:0]           byte_ff, byte_in;
   logic [7:0]           wrap_byte_ff, wrap_byte_in;
   logic                 more_ff, more_in;
   logic                 started_ff, started_in;
   logic [DIG_W-1:0]     dig_ff, dig_in;
   logic [1:0]           step_ff, step_in;
   logic [3:0]           acc_ff, acc_in;
   logic [15:0]          rem_ff, rem_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_rs_ff, rsp_rs_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_take;
   logic                 out_free;
   logic                 load;
   logic [WEIGHT_W-1:0]  weight;
   logic [WEIGHT_W:0]    diff;
   logic                 fits;
   logic [3:0]           acc_next;
   logic                 skip;
   logic [CNT_W:0]       count_plus;
   logic                 hit_line;
   logic                 hit_wrap;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // shared compare/subtract unit: one restoring step of a decimal digit
   assign weight   = digit_weight(dig_ff, step_ff);
   assign diff     = {2'b00, rem_ff} - {1'b0, weight};
   assign fits     = !diff[WEIGHT_W];
   assign acc_next = acc_ff | (fits ? (4'b1000 >> step_ff) : 4'b0000);
   assign skip     = (acc_next == 4'd0) && !started_ff && (dig_ff != DIG_LAST);

   assign count_plus = {1'b0, count_ff} + (CNT_W+1)'(1);
   assign hit_line   = (count_plus == (CNT_W+1)'(LINE_CHARS));
   assign hit_wrap   = (count_plus == (CNT_W+1)'(2 * LINE_CHARS));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_ch.command) inside
                  CMD_INIT:               state_in = S_INIT0;
                  CMD_RAW, CMD_CURSOR:    state_in = S_SINGLE;
                  CMD_CHAR:               state_in = S_DATA;
                  CMD_NUMBER:             state_in = S_CALC;
                  default:                state_in = S_IDLE;
               endcase
            end
         end
         S_INIT0:  if (out_free) state_in = S_INIT1;
         S_INIT1:  if (out_free) state_in = S_INIT2;
         S_INIT2:  if (out_free) state_in = S_IDLE;
         S_SINGLE: if (out_free) state_in = S_IDLE;
         S_DATA: begin
            if (out_free) begin
               if (hit_line || hit_wrap) state_in = S_WRAP;
               else if (more_ff)         state_in = S_CALC;
               else                      state_in = S_IDLE;
            end
         end
         S_WRAP: if (out_free) state_in = more_ff ? S_CALC : S_IDLE;
         S_CALC: if ((step_ff == 2'd3) && !skip) state_in = S_DATA;
      endcase
   end

   // datapath and write generation
   always_comb begin
      byte_in      = byte_ff;
      wrap_byte_in = wrap_byte_ff;
      more_in      = more_ff;
      started_in   = started_ff;
      dig_in       = dig_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      count_in     = count_ff;
      load         = 1'b0;
      rsp_rs_in    = rsp_rs_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               more_in    = 1'b0;
               started_in = 1'b0;
               dig_in     = '0;
               step_in    = '0;
               acc_in     = '0;
               rem_in     = req_ch.number;
               if (req_ch.command == CMD_CURSOR)
                  byte_in = {1'b1, req_ch.row, req_ch.column};
               else
                  byte_in = req_ch.byte_value;
            end
         end
         S_INIT0: begin
            load        = out_free;
            rsp_rs_in   = 1'b0;
            rsp_byte_in = fset_ff;
            rsp_last_in = 1'b0;
         end
         S_INIT1: begin
            load        = out_free;
            rsp_rs_in   = 1'b0;
            rsp_byte_in = dctl_ff;
            rsp_last_in = 1'b0;
         end
         S_INIT2: begin
            load        = out_free;
            rsp_rs_in   = 1'b0;
            rsp_byte_in = CLEAR_DISPLAY;
            rsp_last_in = 1'b1;
            if (out_free) count_in = '0;
         end
         S_SINGLE: begin
            load        = out_free;
            rsp_rs_in   = 1'b0;
            rsp_byte_in = byte_ff;
            rsp_last_in = 1'b1;
         end
         S_DATA: begin
            load        = out_free;
            rsp_rs_in   = 1'b1;
            rsp_byte_in = byte_ff;
            rsp_last_in = !more_ff && !hit_line && !hit_wrap;
            if (out_free) begin
               count_in     = hit_wrap ? '0 : count_plus[CNT_W-1:0];
               wrap_byte_in = hit_wrap ? DDRAM_SET : (DDRAM_SET | LINE2_BASE);
            end
         end
         S_WRAP: begin
            load        = out_free;
            rsp_rs_in   = 1'b0;
            rsp_byte_in = wrap_byte_ff;
            rsp_last_in = !more_ff;
         end
         S_CALC: begin
            if (fits) rem_in = diff[15:0];
            acc_in  = acc_next;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               acc_in = '0;
               dig_in = dig_ff + DIG_W'(1);
               if (!skip) begin
                  // leading zeros are dropped, the ones place always prints
                  started_in = 1'b1;
                  more_in    = (dig_ff != DIG_LAST);
                  byte_in    = ASCII_ZERO | {4'd0, acc_next};
               end
            end
         end
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fset_ff      <= FUNCTION_SET_RESET;
         dctl_ff      <= DISPLAY_CONTROL_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FUNCTION_SET:    fset_ff <= csr_wdata;
               CSR_DISPLAY_CONTROL: dctl_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      wrap_byte_ff <= wrap_byte_in;
      more_ff      <= more_in;
      started_ff   <= started_in;
      dig_ff       <= dig_in;
      step_ff      <= step_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      if (load) begin
         rsp_rs_ff   <= rsp_rs_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.reg_select = rsp_rs_ff;
   assign rsp_ch.bus_byte   = rsp_byte_ff;
   assign rsp_ch.last       = rsp_last_ff;

   `ASSERT_RST(a_count_range, clock, reset,
      count_ff < CNT_W'(2 * LINE_CHARS - 1) || count_ff == CNT_W'(2 * LINE_CHARS - 1),
      "char count out of range")
   `ASSERT_RST(a_last_ends_item, clock, reset,
      (load && rsp_last_in) |=> (state_ff == S_IDLE),
      "last write did not end the request")
   `ASSERT_RST(a_wrap_after_data, clock, reset,
      (state_ff == S_WRAP) |-> ($past(state_ff) == S_DATA || $past(state_ff) == S_WRAP),
      "cursor wrap without a data write")
   `ASSERT_RST(a_digit_index, clock, reset,
      (state_ff == S_CALC) |-> (dig_ff <= DIG_LAST),
      "digit index past the ones place")
   `ASSERT_RST(a_no_load_when_full, clock, reset,
      (rsp_valid_ff && !rsp_ch.ready) |-> !load,
      "output register overwritten while stalled")

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LCD write sequencer. A driver feeds display
// requests from a queue, a predictor works out the bus writes each one
// should produce, and a monitor compares every write with the oldest
// expected one. Both sides idle in random bursts while allow_idle is set.
// ----------------------------------------------------------------------------
module tb;
   import clws_pkg::*;

   localparam int         LINE_CHARS   = LINE_CHARS_DEFAULT;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         HOLD_CYCLES  = 200;
   localparam logic [2:0] CMD_TOP_CODE = 3'd7;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  byte_value;
      logic        row;
      logic [5:0]  column;
      logic [15:0] number;
   } lcd_req_type;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] bus_byte;
      logic       last;
   } lcd_write_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;

   clws_req_if req_if ();
   clws_rsp_if rsp_if ();

   char_lcd_write_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // predictor state
   logic [7:0] fs_word = FUNCTION_SET_RESET;
   logic [7:0] dc_word = DISPLAY_CONTROL_RESET;
   int         shadow_char_count = 0;

   lcd_req_type   req_pending[$];
   lcd_write_type lcd_writes_q[$];
   lcd_req_type   req_cur;
   int            n_queued = 0;
   int            n_accepted = 0;
   int            mismatch_count = 0;
   int            send_gap;
   int            rsp_gap;
   logic          allow_idle = 1'b1;
   logic          hold_start = 1'b0;
   logic          rsp_hold = 1'b0;

   function automatic void add_data_write(ref lcd_write_type run[$], input logic [7:0] code);
      run.push_back('{1'b1, code, 1'b0});
      shadow_char_count++;
      if (shadow_char_count == LINE_CHARS)
         run.push_back('{1'b0, DDRAM_SET | LINE2_BASE, 1'b0});
      if (shadow_char_count >= 2 * LINE_CHARS) begin
         run.push_back('{1'b0, DDRAM_SET, 1'b0});
         shadow_char_count = 0;
      end
   endfunction

   function automatic void predict_writes(input lcd_req_type r);
      lcd_write_type run[$];
      int unsigned   value;
      int unsigned   digits[5];
      int            nd;
      case (r.command)
         CMD_INIT: begin
            run.push_back('{1'b0, fs_word, 1'b0});
            run.push_back('{1'b0, dc_word, 1'b0});
            run.push_back('{1'b0, CLEAR_DISPLAY, 1'b0});
            shadow_char_count = 0;
         end
         CMD_RAW:
            run.push_back('{1'b0, r.byte_value, 1'b0});
         CMD_CHAR:
            add_data_write(run, r.byte_value);
         CMD_CURSOR:
            run.push_back('{1'b0, DDRAM_SET + (r.row ? LINE2_BASE : 8'h00) + 8'(r.column),
                            1'b0});
         CMD_NUMBER: begin
            value = r.number;
            nd = 0;
            do begin
               digits[nd] = value % 10;
               nd++;
               value = value / 10;
            end while (value != 0);
            for (int i = nd - 1; i >= 0; i--)
               add_data_write(run, ASCII_ZERO + 8'(digits[i]));
         end
         default: ;
      endcase
      if (run.size() != 0) begin
         run[run.size() - 1].last = 1'b1;
         foreach (run[i])
            lcd_writes_q.push_back(run[i]);
      end
   endfunction

   function automatic lcd_req_type make_req(input logic [2:0] cmd, input logic [7:0] code,
                                            input logic row, input logic [5:0] col,
                                            input logic [15:0] num);
      lcd_req_type r;
      r.command    = cmd;
      r.byte_value = code;
      r.row        = row;
      r.column     = col;
      r.number     = num;
      return r;
   endfunction

   function automatic lcd_req_type random_req();
      int unsigned edge_nums[10] = '{0, 9, 10, 99, 100, 999, 1000, 9999, 10000, 65535};
      lcd_req_type r;
      int unsigned sel;
      r.byte_value = 8'($urandom_range(0, 255));
      r.row        = 1'($urandom_range(0, 1));
      r.column     = 6'($urandom_range(0, 63));
      case ($urandom_range(0, 3))
         0:       r.number = 16'($urandom_range(0, 99));
         1:       r.number = 16'(edge_nums[$urandom_range(0, 9)]);
         default: r.number = 16'($urandom_range(0, 65535));
      endcase
      sel = $urandom_range(0, 99);
      if (sel < 5)
         r.command = CMD_INIT;
      else if (sel < 15)
         r.command = CMD_RAW;
      else if (sel < 50)
         r.command = CMD_CHAR;
      else if (sel < 60)
         r.command = CMD_CURSOR;
      else if (sel < 95)
         r.command = CMD_NUMBER;
      else
         r.command = 3'($urandom_range(int'(CMD_NUMBER) + 1, int'(CMD_TOP_CODE)));
      return r;
   endfunction

   task automatic queue_req(input lcd_req_type r);
      req_pending.push_back(r);
      n_queued++;
   endtask

   // unused codes are ignored by the block and not counted
   task automatic queue_random(input int count);
      lcd_req_type r;
      int          n;
      n = 0;
      while (n < count) begin
         r = random_req();
         queue_req(r);
         if (r.command <= CMD_NUMBER)
            n++;
      end
   endtask

   task automatic wait_drained();
      while (n_accepted != n_queued || lcd_writes_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_FUNCTION_SET:    fs_word = val;
         CSR_DISPLAY_CONTROL: dc_word = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap     <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_writes(req_cur);
            n_accepted++;
         end
         if (req_if.valid && !req_if.ready) begin
            // item still on offer, keep it
         end else if (send_gap > 0) begin
            send_gap     <= send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (allow_idle && $urandom_range(0, 3) == 0) begin
            send_gap     <= $urandom_range(0, 7);
            req_if.valid <= 1'b0;
         end else if (req_pending.size() != 0) begin
            req_cur = req_pending.pop_front();
            req_if.valid      <= 1'b1;
            req_if.command    <= req_cur.command;
            req_if.byte_value <= req_cur.byte_value;
            req_if.row        <= req_cur.row;
            req_if.column     <= req_cur.column;
            req_if.number     <= req_cur.number;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // bus write monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_gap      <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (lcd_writes_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: expected no write, got rs=%0d byte=%02h last=%0d", $time,
                        rsp_if.reg_select, rsp_if.bus_byte, rsp_if.last);
            end else begin
               lcd_write_type exp_w;
               exp_w = lcd_writes_q.pop_front();
               if (rsp_if.reg_select !== exp_w.reg_select
                   || rsp_if.bus_byte !== exp_w.bus_byte
                   || rsp_if.last !== exp_w.last) begin
                  mismatch_count++;
                  $display("%0t: exp rs=%0d byte=%02h last=%0d, got rs=%0d byte=%02h last=%0d",
                           $time, exp_w.reg_select, exp_w.bus_byte, exp_w.last,
                           rsp_if.reg_select, rsp_if.bus_byte, rsp_if.last);
               end
            end
         end
         if (rsp_hold) begin
            rsp_if.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap      <= rsp_gap - 1;
            rsp_if.ready <= 1'b0;
         end else if (allow_idle && $urandom_range(0, 3) == 0) begin
            rsp_gap      <= $urandom_range(0, 7);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // long receiver stall so the block backs up into the request side
   initial begin
      wait (hold_start);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_FUNCTION_SET;
      csr_wdata         = 8'h00;
      req_if.valid      = 1'b0;
      req_if.command    = CMD_INIT;
      req_if.byte_value = 8'h00;
      req_if.row        = 1'b0;
      req_if.column     = 6'd0;
      req_if.number     = 16'd0;
      rsp_if.ready      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: default init words, field extremes, unused codes, both wraps
      queue_req(make_req(CMD_INIT,   8'h00, 1'b0, 6'd0,  16'd0));
      queue_req(make_req(CMD_RAW,    8'h00, 1'b0, 6'd0,  16'd0));
      queue_req(make_req(CMD_RAW,    8'hFF, 1'b1, 6'd63, 16'hFFFF));
      queue_req(make_req(CMD_CURSOR, 8'h00, 1'b0, 6'd0,  16'd0));
      queue_req(make_req(CMD_CURSOR, 8'hFF, 1'b1, 6'd63, 16'd0));
      queue_req(make_req(CMD_CURSOR, 8'h00, 1'b0, 6'd63, 16'd0));
      queue_req(make_req(CMD_CHAR,   8'h00, 1'b0, 6'd0,  16'd0));
      queue_req(make_req(CMD_CHAR,   8'hFF, 1'b0, 6'd0,  16'd0));
      queue_req(make_req(CMD_NUMBER, 8'h00, 1'b0, 6'd0,  16'd0));
      queue_req(make_req(CMD_NUMBER, 8'h00, 1'b0, 6'd0,  16'd65535));
      queue_req(make_req(CMD_NUMBER, 8'h00, 1'b0, 6'd0,  16'd10000));
      queue_req(make_req(CMD_NUMBER + 3'd1, 8'h55, 1'b1, 6'd21, 16'd77));
      queue_req(make_req(CMD_NUMBER + 3'd2, 8'hAA, 1'b0, 6'd42, 16'd88));
      queue_req(make_req(CMD_TOP_CODE, 8'hFF, 1'b1, 6'd63, 16'hFFFF));
      queue_req(make_req(CMD_NUMBER, 8'h00, 1'b0, 6'd0,  16'd9));
      // count is 14 here: second-line jump lands between digits
      queue_req(make_req(CMD_NUMBER, 8'h00, 1'b0, 6'd0,  16'd12345));
      queue_req(make_req(CMD_NUMBER, 8'h00, 1'b0, 6'd0,  16'd9999));
      queue_req(make_req(CMD_NUMBER, 8'h00, 1'b0, 6'd0,  16'd65535));
      queue_req(make_req(CMD_NUMBER, 8'h00, 1'b0, 6'd0,  16'd100));
      // 32nd character: back to first line
      queue_req(make_req(CMD_CHAR,   8'h41, 1'b0, 6'd0,  16'd0));
      queue_req(make_req(CMD_RAW,    8'h01, 1'b0, 6'd0,  16'd0));
      wait_drained();

      write_csr(CSR_FUNCTION_SET, 8'h00);
      write_csr(CSR_DISPLAY_CONTROL, 8'h00);
      queue_req(make_req(CMD_INIT, 8'h00, 1'b0, 6'd0, 16'd0));
      queue_random(70);
      wait_drained();

      write_csr(CSR_FUNCTION_SET, 8'hFF);
      write_csr(CSR_DISPLAY_CONTROL, 8'hFF);
      hold_start = 1'b1;
      queue_req(make_req(CMD_INIT, 8'h00, 1'b0, 6'd0, 16'd0));
      queue_random(70);
      wait_drained();

      write_csr(CSR_FUNCTION_SET, 8'($urandom_range(0, 255)));
      write_csr(CSR_DISPLAY_CONTROL, 8'($urandom_range(0, 255)));
      allow_idle = 1'b0;
      queue_req(make_req(CMD_INIT, 8'h00, 1'b0, 6'd0, 16'd0));
      queue_random(70);
      wait_drained();

      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
